[rtl/etach_pkg.sv]
// ----------------------------------------------------------------------------
// Edge interval tachometer package
// Word types, register indexes, reset values and the control word format
// shared by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package etach_pkg;

	localparam int LOCKOUT_W = 20;
	localparam int SCALE_W   = 32;
	localparam int LIMIT_W   = 16;
	localparam int RPM_W     = 16;
	localparam int COUNT_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int QUO_W     = SCALE_W;
	localparam int ITER_W    = $clog2(QUO_W);

	localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 20'd5000;
	localparam logic [SCALE_W-1:0]   SCALE_RESET   = 32'd15000000;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 16'd3600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCKOUT = 2'd0,
		REG_SCALE   = 2'd1,
		REG_LIMIT   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic pin_level;
		logic read_request;
	} tick_t;

	typedef struct packed {
		logic [RPM_W-1:0]   rpm;
		logic [COUNT_W-1:0] edge_total;
		logic               edge_seen;
	} result_t;

	typedef enum logic [2:0] {
		STEP_IDLE,
		STEP_EDGE,
		STEP_SPAN,
		STEP_DIV,
		STEP_CLAMP,
		STEP_OUT
	} step_t;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_TICK,
		HOLD_DIV,
		HOLD_RESULT
	} hold_t;

	typedef enum logic [1:0] {
		JMP_NEVER,
		JMP_ALWAYS,
		JMP_NO_READ
	} jump_t;

	typedef struct packed {
		logic  take_in;
		logic  op_edge;
		logic  op_div_load;
		logic  op_div_step;
		logic  op_clamp;
		logic  op_out;
		hold_t hold;
		jump_t jump;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic tick_valid;
		logic read_pending;
		logic div_last;
		logic result_busy;
	} status_t;

endpackage

[rtl/etach_seq.sv]
// ----------------------------------------------------------------------------
// Edge interval tachometer sequencer
// Step counter and control store; each step issues one control word and
// either holds, jumps or falls through to the next step.
// ----------------------------------------------------------------------------
module etach_seq import etach_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	step_t step_q;
	step_t step_next;
	logic  hold_now;
	logic  jump_now;

	always_comb begin
		ctrl = '{take_in: 1'b0, op_edge: 1'b0, op_div_load: 1'b0, op_div_step: 1'b0,
			op_clamp: 1'b0, op_out: 1'b0, hold: HOLD_NONE, jump: JMP_NEVER,
			target: STEP_IDLE};
		unique case (step_q)
			STEP_IDLE: begin
				ctrl.take_in = 1'b1;
				ctrl.hold    = HOLD_TICK;
			end
			STEP_EDGE: begin
				ctrl.op_edge = 1'b1;
				ctrl.jump    = JMP_NO_READ;
				ctrl.target  = STEP_IDLE;
			end
			STEP_SPAN: begin
				ctrl.op_div_load = 1'b1;
			end
			STEP_DIV: begin
				ctrl.op_div_step = 1'b1;
				ctrl.hold        = HOLD_DIV;
			end
			STEP_CLAMP: begin
				ctrl.op_clamp = 1'b1;
			end
			STEP_OUT: begin
				ctrl.op_out = 1'b1;
				ctrl.hold   = HOLD_RESULT;
				ctrl.jump   = JMP_ALWAYS;
				ctrl.target = STEP_IDLE;
			end
			default: begin
				ctrl.jump   = JMP_ALWAYS;
				ctrl.target = STEP_IDLE;
			end
		endcase
	end

	always_comb begin
		unique case (ctrl.hold)
			HOLD_NONE:   hold_now = 1'b0;
			HOLD_TICK:   hold_now = !status.tick_valid;
			HOLD_DIV:    hold_now = !status.div_last;
			HOLD_RESULT: hold_now = status.result_busy;
			default:     hold_now = 1'b0;
		endcase
		unique case (ctrl.jump)
			JMP_NEVER:   jump_now = 1'b0;
			JMP_ALWAYS:  jump_now = 1'b1;
			JMP_NO_READ: jump_now = !status.read_pending;
			default:     jump_now = 1'b0;
		endcase
		if (hold_now) begin
			step_next = step_q;
		end else if (jump_now) begin
			step_next = ctrl.target;
		end else begin
			step_next = step_t'(step_q + 3'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

[rtl/etach_dp.sv]
// ----------------------------------------------------------------------------
// Edge interval tachometer datapath
// Configuration registers, time base, edge state, a one bit per cycle
// restoring divider, the clamp and the result register.
// ----------------------------------------------------------------------------
module etach_dp import etach_pkg::*; #(
	parameter int TIME_WIDTH = 32,
	parameter int RPM_WIDTH  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_t                 ctrl,
	output status_t               status,
	input  logic                  tick_valid,
	input  tick_t                 tick_word,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result_word,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CMP_W = (TIME_WIDTH > LOCKOUT_W) ? TIME_WIDTH : LOCKOUT_W;
	localparam logic [RPM_W-1:0] RPM_MAX = RPM_W'((64'd1 << RPM_WIDTH) - 64'd1);

	logic [LOCKOUT_W-1:0]  lockout_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [LIMIT_W-1:0]    limit_q;

	logic [TIME_WIDTH-1:0] time_q;
	logic [TIME_WIDTH-1:0] tick_time_q;
	logic [TIME_WIDTH-1:0] last_edge_q;
	logic [TIME_WIDTH-1:0] last_interval_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  sensor_q;
	logic                  prev_q;
	logic                  primed_q;
	logic                  any_edge_q;
	logic                  pin_q;
	logic                  read_q;

	logic [TIME_WIDTH-1:0] divisor_q;
	logic [TIME_WIDTH-1:0] rem_q;
	logic [QUO_W-1:0]      quo_q;
	logic [ITER_W-1:0]     iter_q;
	logic [RPM_W-1:0]      rpm_q;
	logic                  result_valid_q;
	result_t               result_q;

	logic [TIME_WIDTH-1:0] elapsed;
	logic                  lockout_over;
	logic [TIME_WIDTH-1:0] span;
	logic [TIME_WIDTH:0]   rem_shift;
	logic [TIME_WIDTH:0]   rem_diff;
	logic                  quo_bit;
	logic [RPM_W-1:0]      cap;
	logic                  tick_accept;
	logic                  result_load;

	assign tick_accept = tick_valid && ctrl.take_in;
	assign result_load = ctrl.op_out && !status.result_busy;

	assign elapsed      = tick_time_q - last_edge_q;
	assign lockout_over = CMP_W'(elapsed) > CMP_W'(lockout_q);
	assign span         = (elapsed > last_interval_q) ? elapsed : last_interval_q;

	assign rem_shift = {rem_q, quo_q[QUO_W-1]};
	assign rem_diff  = rem_shift - {1'b0, divisor_q};
	assign quo_bit   = !rem_diff[TIME_WIDTH];

	assign cap = (RPM_W'(limit_q) > RPM_MAX) ? RPM_MAX : RPM_W'(limit_q);

	assign status.tick_valid   = tick_valid;
	assign status.read_pending = read_q;
	assign status.div_last     = iter_q == ITER_W'(QUO_W - 1);
	assign status.result_busy  = result_valid_q && result_stall;

	assign result_valid = result_valid_q;
	assign result_word  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LOCKOUT_RESET;
			scale_q   <= SCALE_RESET;
			limit_q   <= LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOCKOUT: lockout_q <= cfg_data[LOCKOUT_W-1:0];
				REG_SCALE:   scale_q   <= cfg_data[SCALE_W-1:0];
				REG_LIMIT:   limit_q   <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q          <= '0;
			last_edge_q     <= '0;
			last_interval_q <= '0;
			count_q         <= '0;
			sensor_q        <= 1'b0;
			prev_q          <= 1'b0;
			primed_q        <= 1'b0;
			any_edge_q      <= 1'b0;
			read_q          <= 1'b0;
		end else begin
			if (tick_accept) begin
				read_q <= tick_word.read_request;
			end
			if (ctrl.op_edge) begin
				time_q <= time_q + 1'b1;
				prev_q <= pin_q;
				if (!primed_q) begin
					sensor_q <= pin_q;
					primed_q <= 1'b1;
				end else if (pin_q != prev_q && pin_q != sensor_q && lockout_over) begin
					sensor_q        <= !sensor_q;
					last_interval_q <= elapsed;
					last_edge_q     <= tick_time_q;
					count_q         <= count_q + 1'b1;
					any_edge_q      <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_accept) begin
			pin_q       <= tick_word.pin_level;
			tick_time_q <= time_q;
		end
		if (ctrl.op_div_load) begin
			divisor_q <= span;
			rem_q     <= '0;
			quo_q     <= scale_q;
			iter_q    <= '0;
		end else if (ctrl.op_div_step) begin
			rem_q  <= quo_bit ? rem_diff[TIME_WIDTH-1:0] : rem_shift[TIME_WIDTH-1:0];
			quo_q  <= {quo_q[QUO_W-2:0], quo_bit};
			iter_q <= iter_q + 1'b1;
		end
		if (ctrl.op_clamp) begin
			if (!any_edge_q) begin
				rpm_q <= '0;
			end else if (quo_q > QUO_W'(cap)) begin
				rpm_q <= cap;
			end else begin
				rpm_q <= quo_q[RPM_W-1:0];
			end
		end
		if (result_load) begin
			result_q <= '{rpm: rpm_q, edge_total: count_q, edge_seen: any_edge_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/edge_interval_tachometer.sv]
// ----------------------------------------------------------------------------
// Edge interval tachometer
// Each tick word is one microsecond of sensor pin; a read request returns the
// speed as scale over the larger of last interval and time since last edge.
// ----------------------------------------------------------------------------
// A tick word runs the idle and edge steps; a read request adds the span,
// divide (32 iterations of the one bit per cycle divider), clamp and output
// steps, output holding while the previous result waits in the output
// register. The next tick word is taken while a result waits to be read.
// Configuration writes are always ready and apply on the next cycle.
module edge_interval_tachometer import etach_pkg::*; #(
	parameter int TIME_WIDTH = 32,
	parameter int RPM_WIDTH  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  tick_t                 tick_word,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result_word,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_t   ctrl;
	status_t status;

	assign tick_stall = !ctrl.take_in;
	assign cfg_ready  = 1'b1;

	etach_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	etach_dp #(
		.TIME_WIDTH (TIME_WIDTH),
		.RPM_WIDTH  (RPM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.status       (status),
		.tick_valid   (tick_valid),
		.tick_word    (tick_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

endmodule

[rtl/etach_chk.sv]
// ----------------------------------------------------------------------------
// Edge interval tachometer checker
// Port level properties of the tachometer, bound to the top level.
// ----------------------------------------------------------------------------
module etach_chk import etach_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    tick_valid,
	input logic    tick_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result_word
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_word))
		else $error("Stalled result word changed or was dropped.");

	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall |=> tick_stall)
		else $error("A tick word was taken while the previous one was in work.");

	a_no_edge_rpm: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_word.edge_seen |-> result_word.rpm == '0)
		else $error("Nonzero speed reported before any edge.");

	a_no_edge_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_word.edge_seen |-> result_word.edge_total == '0)
		else $error("Edges counted without an edge seen.");

endmodule

bind edge_interval_tachometer etach_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick_valid),
	.tick_stall   (tick_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_word  (result_word)
);
